>>> rtl/core/tfbc_pkg.sv
// shared types and constants for the tcp flow byte counter table
package tfbc_pkg;

   localparam int ADDR_W  = 64;
   localparam int PORT_W  = 16;
   localparam int BYTES_W = 32;
   localparam int CNT_W   = 64;
   localparam int TST_W   = 4;
   localparam int FAM_W   = 16;
   localparam int SLOT_W  = 7;

   localparam logic [FAM_W-1:0] FAM_IPV4 = 16'd2;
   localparam logic [FAM_W-1:0] FAM_IPV6 = 16'd10;

   localparam logic [TST_W-1:0] ST_ESTABLISHED = 4'd1;
   localparam logic [TST_W-1:0] ST_SYN_SENT    = 4'd2;
   localparam logic [TST_W-1:0] ST_SYN_RECV    = 4'd3;

   typedef enum logic [1:0] {
      OP_RECV  = 2'd0,
      OP_SEND  = 2'd1,
      OP_STATE = 2'd2,
      OP_STATE_ALT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_COUNTED    = 3'd0,
      STS_INSERTED   = 3'd1,
      STS_FAM_IGNORE = 3'd2,
      STS_FULL       = 3'd3,
      STS_STATE_SET  = 3'd4,
      STS_STATE_IGN  = 3'd5,
      STS_UNKNOWN    = 3'd6,
      STS_RSVD       = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [FAM_W-1:0]   family;
      logic [ADDR_W-1:0]  remote_addr_hi;
      logic [ADDR_W-1:0]  remote_addr_lo;
      logic [ADDR_W-1:0]  local_addr_hi;
      logic [ADDR_W-1:0]  local_addr_lo;
      logic [PORT_W-1:0]  remote_port;
      logic [PORT_W-1:0]  local_port;
      logic [BYTES_W-1:0] byte_count;
      logic [TST_W-1:0]   new_state;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  recv_total;
      logic [CNT_W-1:0]  sent_total;
      logic [TST_W-1:0]  conn_state;
      logic              is_ipv4;
   } rsp_payload_type;

   // transaction traveling down the cell row
   typedef struct packed {
      logic               valid;
      logic               done;
      logic               state_op;
      logic               recv_op;
      logic               ipv4;
      logic [ADDR_W-1:0]  rem_hi;
      logic [ADDR_W-1:0]  rem_lo;
      logic [ADDR_W-1:0]  loc_hi;
      logic [ADDR_W-1:0]  loc_lo;
      logic [2*PORT_W-1:0] ports;
      logic [BYTES_W-1:0] nbytes;
      logic [TST_W-1:0]   nst;
      rsp_payload_type    res;
   } pkt_type;

endpackage

>>> rtl/core/tfbc_if.sv
// valid/ready channel interfaces for requests and responses
interface tfbc_req_if;
   import tfbc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tfbc_rsp_if;
   import tfbc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/tcp_flow_byte_counter_table.sv
// tcp flow byte counter table: row of entry cells that events walk through
//
//   channel  | dir | handshake          | payload
//   req      | in  | req.valid/ready    | op, family, addresses, ports, byte_count, new_state
//   rsp      | out | rsp.valid/ready    | status, slot, recv_total, sent_total, conn_state, is_ipv4
//
// each transaction moves one cell per cycle while rsp is not stalled; a response leaves the
// last of the TABLE_ENTRIES cells, and a new transaction can be accepted in every such cycle.
// the cell row is one pipeline: a stalled response holds every cell in place.
// reset clears all entry valid bits and the pipeline valid bits.
module tcp_flow_byte_counter_table #(
   parameter int TABLE_ENTRIES = 128
) (
   input logic       clock,
   input logic       reset,
   tfbc_req_if.sink  req,
   tfbc_rsp_if.source rsp
);
   import tfbc_pkg::*;

   pkt_type chain [TABLE_ENTRIES+1];
   pkt_type tail;
   logic    adv;
   logic    is_v4, fam_ok, syn_ign;

   assign adv       = !chain[TABLE_ENTRIES].valid || rsp.ready;
   assign req.ready = adv;

   assign is_v4   = req.payload.family == FAM_IPV4;
   assign fam_ok  = is_v4 || req.payload.family == FAM_IPV6;
   assign syn_ign = req.payload.op[1] &&
                    (req.payload.new_state == ST_SYN_SENT ||
                     req.payload.new_state == ST_SYN_RECV);

   always_comb begin
      chain[0].valid    = req.valid;
      chain[0].done     = syn_ign || !fam_ok;
      chain[0].state_op = req.payload.op[1];
      chain[0].recv_op  = req.payload.op == OP_RECV;
      chain[0].ipv4     = is_v4;
      chain[0].rem_hi   = is_v4 ? '0 : req.payload.remote_addr_hi;
      chain[0].loc_hi   = is_v4 ? '0 : req.payload.local_addr_hi;
      chain[0].rem_lo   = is_v4 ? {32'd0, req.payload.remote_addr_lo[31:0]}
                                : req.payload.remote_addr_lo;
      chain[0].loc_lo   = is_v4 ? {32'd0, req.payload.local_addr_lo[31:0]}
                                : req.payload.local_addr_lo;
      chain[0].ports    = {req.payload.remote_port, req.payload.local_port};
      chain[0].nbytes   = req.payload.byte_count;
      chain[0].nst      = req.payload.new_state;
      chain[0].res      = '0;
      chain[0].res.status = syn_ign ? STS_STATE_IGN : STS_FAM_IGNORE;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      tfbc_cell #(.IDX(i)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .pkt_in (chain[i]),
         .pkt_out(chain[i+1])
      );
   end

   // no cell claimed it: the table is full; a state change then reports an unknown connection
   always_comb begin
      tail = chain[TABLE_ENTRIES];
      if (!tail.done) begin
         tail.res        = '0;
         tail.res.status = tail.state_op ? STS_UNKNOWN : STS_FULL;
      end
   end

   assign rsp.valid   = tail.valid;
   assign rsp.payload = tail.res;

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.payload.status == STS_FULL || rsp.payload.status == STS_UNKNOWN ||
                    rsp.payload.status == STS_FAM_IGNORE ||
                    rsp.payload.status == STS_STATE_IGN)
      |-> rsp.payload.recv_total == '0 && rsp.payload.sent_total == '0 &&
          rsp.payload.conn_state == '0 && rsp.payload.slot == '0)
      else $error("dropped event carries entry data");

   a_insert_est: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status == STS_INSERTED
      |-> rsp.payload.conn_state == ST_ESTABLISHED &&
          (rsp.payload.recv_total == '0 || rsp.payload.sent_total == '0))
      else $error("inserted entry not fresh");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.status != STS_RSVD)
      else $error("reserved status code");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(chain[TABLE_ENTRIES].res))
      else $error("tail moved while stalled");

endmodule

>>> rtl/core/tfbc_cell.sv
// one table entry: key match, counter or state update, insert into a free entry
module tfbc_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  tfbc_pkg::pkt_type pkt_in,
   output tfbc_pkg::pkt_type pkt_out
);
   import tfbc_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX % (2**SLOT_W));

   logic               valid_ff, valid_in;
   logic [ADDR_W-1:0]  rem_hi_ff, rem_hi_in, rem_lo_ff, rem_lo_in;
   logic [ADDR_W-1:0]  loc_hi_ff, loc_hi_in, loc_lo_ff, loc_lo_in;
   logic [2*PORT_W-1:0] ports_ff, ports_in;
   logic [CNT_W-1:0]   recv_ff, recv_in, sent_ff, sent_in;
   logic [TST_W-1:0]   tst_ff, tst_in;
   logic               v4_ff, v4_in;
   pkt_type            pkt_ff, pkt_in_nx;
   logic               hit;

   assign hit = valid_ff && rem_hi_ff == pkt_in.rem_hi && rem_lo_ff == pkt_in.rem_lo &&
                loc_hi_ff == pkt_in.loc_hi && loc_lo_ff == pkt_in.loc_lo &&
                ports_ff == pkt_in.ports;

   always_comb begin
      valid_in  = valid_ff;
      rem_hi_in = rem_hi_ff;
      rem_lo_in = rem_lo_ff;
      loc_hi_in = loc_hi_ff;
      loc_lo_in = loc_lo_ff;
      ports_in  = ports_ff;
      recv_in   = recv_ff;
      sent_in   = sent_ff;
      tst_in    = tst_ff;
      v4_in     = v4_ff;
      pkt_in_nx = pkt_in;
      if (pkt_in.valid && !pkt_in.done) begin
         if (hit) begin
            pkt_in_nx.done = 1'b1;
            if (pkt_in.state_op) begin
               tst_in = pkt_in.nst;
               pkt_in_nx.res.status = STS_STATE_SET;
            end else begin
               if (pkt_in.recv_op) recv_in = recv_ff + CNT_W'(pkt_in.nbytes);
               else                sent_in = sent_ff + CNT_W'(pkt_in.nbytes);
               pkt_in_nx.res.status = STS_COUNTED;
            end
            pkt_in_nx.res.slot       = MY_SLOT;
            pkt_in_nx.res.recv_total = recv_in;
            pkt_in_nx.res.sent_total = sent_in;
            pkt_in_nx.res.conn_state = tst_in;
            pkt_in_nx.res.is_ipv4    = v4_ff;
         end else if (!valid_ff) begin
            // entries fill from the low end, so the first free one ends the search
            pkt_in_nx.done = 1'b1;
            if (pkt_in.state_op) begin
               pkt_in_nx.res.status = STS_UNKNOWN;
            end else begin
               valid_in  = 1'b1;
               rem_hi_in = pkt_in.rem_hi;
               rem_lo_in = pkt_in.rem_lo;
               loc_hi_in = pkt_in.loc_hi;
               loc_lo_in = pkt_in.loc_lo;
               ports_in  = pkt_in.ports;
               recv_in   = pkt_in.recv_op ? CNT_W'(pkt_in.nbytes) : '0;
               sent_in   = pkt_in.recv_op ? '0 : CNT_W'(pkt_in.nbytes);
               tst_in    = ST_ESTABLISHED;
               v4_in     = pkt_in.ipv4;
               pkt_in_nx.res.status     = STS_INSERTED;
               pkt_in_nx.res.slot       = MY_SLOT;
               pkt_in_nx.res.recv_total = recv_in;
               pkt_in_nx.res.sent_total = sent_in;
               pkt_in_nx.res.conn_state = ST_ESTABLISHED;
               pkt_in_nx.res.is_ipv4    = pkt_in.ipv4;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         pkt_ff.valid <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
         pkt_ff   <= pkt_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_hi_ff <= rem_hi_in;
         rem_lo_ff <= rem_lo_in;
         loc_hi_ff <= loc_hi_in;
         loc_lo_ff <= loc_lo_in;
         ports_ff  <= ports_in;
         recv_ff   <= recv_in;
         sent_ff   <= sent_in;
         tst_ff    <= tst_in;
         v4_ff     <= v4_in;
      end
   end

   assign pkt_out = pkt_ff;

endmodule

>>> bench/tb_tfbc_if.sv
// valid/ready interfaces are part of the rtl; this file holds the bench event item type
`timescale 1ns / 100ps
package tb_tfbc_items;
   import tfbc_pkg::*;
   // a pending request with the idle cycles to insert before offering it
   typedef struct {
      req_payload_type pl;
      int unsigned     gap;
      bit              drain;
   } flow_event_type;
endpackage

>>> bench/tb.sv
// testbench for the tcp flow byte counter table: random socket events against a flow-table predictor
`timescale 1ns / 100ps
module tb;
   import tfbc_pkg::*;
   import tb_tfbc_items::*;

   localparam int ENTRIES = 128;
   localparam int LATENCY = ENTRIES + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfbc_req_if req_ch ();
   tfbc_rsp_if rsp_ch ();

   tcp_flow_byte_counter_table #(.TABLE_ENTRIES(ENTRIES)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #2 clock = ~clock;

   // predictor state
   bit              flow_used[ENTRIES];
   logic [63:0]     flow_rh[ENTRIES], flow_rl[ENTRIES], flow_lh[ENTRIES], flow_ll[ENTRIES];
   logic [31:0]     flow_ports[ENTRIES];
   logic [63:0]     flow_rx[ENTRIES], flow_tx[ENTRIES];
   logic [3:0]      flow_tcp[ENTRIES];
   bit              flow_v4[ENTRIES];

   flow_event_type  pending_events[$];
   rsp_payload_type expected_rsp[$];
   int              error_count = 0;
   bit              stim_done = 0;
   int              hold_off = 0;
   int              accepted_count = 0;
   bit              long_stall_done = 0;

   // known keys reused so that hits dominate
   req_payload_type key_pool[$];

   function automatic rsp_payload_type predict_flow(req_payload_type r);
      rsp_payload_type o;
      logic [63:0] rh, rl, lh, ll;
      logic [31:0] pt;
      int idx;
      bit st_op;
      o = '0;
      st_op = r.op[1];
      rh = r.remote_addr_hi; rl = r.remote_addr_lo;
      lh = r.local_addr_hi;  ll = r.local_addr_lo;
      pt = {r.remote_port, r.local_port};
      idx = -1;
      if (st_op && (r.new_state == ST_SYN_SENT || r.new_state == ST_SYN_RECV)) begin
         o.status = STS_STATE_IGN;
         return o;
      end
      if (r.family != FAM_IPV4 && r.family != FAM_IPV6) begin
         o.status = STS_FAM_IGNORE;
         return o;
      end
      if (r.family == FAM_IPV4) begin
         rh = '0; lh = '0; rl[63:32] = '0; ll[63:32] = '0;
      end
      for (int i = 0; i < ENTRIES; i++)
         if (idx < 0 && flow_used[i] && flow_rh[i] == rh && flow_rl[i] == rl &&
             flow_lh[i] == lh && flow_ll[i] == ll && flow_ports[i] == pt)
            idx = i;
      if (st_op) begin
         if (idx < 0) begin
            o.status = STS_UNKNOWN;
            return o;
         end
         flow_tcp[idx] = r.new_state;
         o.status = STS_STATE_SET;
      end else begin
         o.status = STS_COUNTED;
         if (idx < 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (idx < 0 && !flow_used[i]) idx = i;
            if (idx < 0) begin
               o.status = STS_FULL;
               return o;
            end
            flow_used[idx] = 1; flow_rh[idx] = rh; flow_rl[idx] = rl;
            flow_lh[idx] = lh; flow_ll[idx] = ll; flow_ports[idx] = pt;
            flow_rx[idx] = '0; flow_tx[idx] = '0;
            flow_tcp[idx] = ST_ESTABLISHED; flow_v4[idx] = (r.family == FAM_IPV4);
            o.status = STS_INSERTED;
         end
         if (r.op == OP_RECV) flow_rx[idx] += 64'(r.byte_count);
         else flow_tx[idx] += 64'(r.byte_count);
      end
      o.slot = idx[6:0];
      o.recv_total = flow_rx[idx];
      o.sent_total = flow_tx[idx];
      o.conn_state = flow_tcp[idx];
      o.is_ipv4 = flow_v4[idx];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_payload_type rand_key(bit v4);
      req_payload_type r;
      r = '0;
      r.family = v4 ? FAM_IPV4 : FAM_IPV6;
      r.remote_addr_hi = rand64(); r.remote_addr_lo = rand64();
      r.local_addr_hi = rand64();  r.local_addr_lo = rand64();
      r.remote_port = 16'($urandom()); r.local_port = 16'($urandom());
      return r;
   endfunction

   task automatic queue_event(req_payload_type r, int unsigned gap, bit drain);
      flow_event_type e;
      e.pl = r; e.gap = gap; e.drain = drain;
      pending_events.push_back(e);
   endtask

   // driver
   int unsigned gap_left = 0;
   bit          gap_loaded = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold the offered transaction
      end else begin
         if (pending_events.size() != 0 && !gap_loaded) begin
            gap_left = pending_events[0].gap;
            gap_loaded = 1;
         end
         if (pending_events.size() == 0) begin
            req_ch.valid <= 1'b0;
            stim_done = 1;
         end else if (pending_events[0].drain && expected_rsp.size() != 0) begin
            req_ch.valid <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_events[0].pl;
         end
      end
   end

   // acceptance and prediction at the rising edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_rsp.push_back(predict_flow(req_ch.payload));
         void'(pending_events.pop_front());
         gap_loaded = 0;
         accepted_count++;
      end
   end

   // receiver stall control
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_ch.ready <= 1'b0;
      end else if (!long_stall_done && accepted_count >= 300) begin
         // a long receiver stall while the sender keeps offering
         long_stall_done = 1;
         hold_off = 600;
         rsp_ch.ready <= 1'b0;
      end else begin
         int unsigned r;
         r = $urandom_range(0, 99);
         if (r < 2) hold_off = $urandom_range(8, 40);
         rsp_ch.ready <= (r >= 25) || stim_done;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_payload_type got, want;
         got = rsp_ch.payload;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(got.status), '0);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status) report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.slot !== want.slot) report_mismatch("slot", 64'(got.slot), 64'(want.slot));
            if (got.recv_total !== want.recv_total)
               report_mismatch("recv_total", got.recv_total, want.recv_total);
            if (got.sent_total !== want.sent_total)
               report_mismatch("sent_total", got.sent_total, want.sent_total);
            if (got.conn_state !== want.conn_state)
               report_mismatch("conn_state", 64'(got.conn_state), 64'(want.conn_state));
            if (got.is_ipv4 !== want.is_ipv4)
               report_mismatch("is_ipv4", 64'(got.is_ipv4), 64'(want.is_ipv4));
         end
      end
   end

   // stimulus
   initial begin
      req_payload_type r, k;
      int n;
      for (int i = 0; i < ENTRIES; i++) flow_used[i] = 0;

      // directed: extremes, every op, special cases
      r = rand_key(1);
      r.remote_addr_hi = '1; r.remote_addr_lo = '1; r.local_addr_hi = '1; r.local_addr_lo = '1;
      r.remote_port = '1; r.local_port = '1;
      r.op = OP_RECV; r.byte_count = '1; queue_event(r, 0, 0);       // insert ipv4, upper bits dropped
      r.remote_addr_hi = '0; r.local_addr_lo = 64'h0000_0000_ffff_ffff;
      r.op = OP_SEND; queue_event(r, 0, 0);                           // same ipv4 key hits
      r.op = OP_STATE; r.new_state = 4'hf; queue_event(r, 0, 0);
      r.op = OP_STATE_ALT; r.new_state = '0; queue_event(r, 0, 0);
      r.new_state = ST_SYN_SENT; r.family = 16'hffff; queue_event(r, 0, 0);
      r.new_state = ST_SYN_RECV; queue_event(r, 0, 0);
      r.op = OP_RECV; queue_event(r, 0, 0);                           // unknown family
      r.family = '0; queue_event(r, 0, 0);
      k = rand_key(0); k.op = OP_STATE; k.new_state = 4'd7; queue_event(k, 0, 0); // unknown conn
      k.op = OP_RECV; k.byte_count = '0; queue_event(k, 0, 0);        // ipv6 insert
      k.byte_count = '1;
      for (int i = 0; i < 4; i++) queue_event(k, 0, 0);               // counter grows past 32 bits
      k = '0; k.family = FAM_IPV6; k.op = OP_SEND; queue_event(k, 0, 0);

      // random: mostly hits on known keys, inserts until the table fills, then drops
      n = 0;
      while (n < 1450) begin
         int unsigned sel;
         sel = $urandom_range(0, 99);
         if (key_pool.size() == 0 || sel < 12) begin
            r = rand_key(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0) r.family = 16'($urandom());
            if (key_pool.size() < 200) key_pool.push_back(r);
         end else begin
            r = key_pool[$urandom_range(0, key_pool.size() - 1)];
            // ipv4 upper bits are don't-care
            if (r.family == FAM_IPV4 && $urandom_range(0, 1)) begin
               r.remote_addr_hi = rand64(); r.local_addr_lo[63:32] = $urandom();
            end
         end
         r.op = op_type'($urandom_range(0, 3));
         r.byte_count = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff - $urandom_range(0, 3)
                                                     : $urandom();
         r.new_state = 4'($urandom());
         queue_event(r, pick_gap(), n == 700 || n == 1100);
         n++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_events.size() == 0);
      fork
         wait (expected_rsp.size() == 0);
         repeat (200000) @(posedge clock);
      join_any
      disable fork;
      repeat (LATENCY) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("PASS tcp_flow_byte_counter_table");
      else
         $display("FAIL tcp_flow_byte_counter_table");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL tcp_flow_byte_counter_table");
      $finish;
   end
endmodule
